// ===== sv/assert_macros.svh =====
// Assertion macros shared by the alarm qualifier modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define AHDL_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define AHDL_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/ahdl_pkg.sv =====
// Shared types, codes and helpers of the alarm qualifier.
// Depends on nothing; imported by every module of the block.
package ahdl_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int TIME_WIDTH  = 48;
   localparam int SPAN_WIDTH  = 32;
   localparam int BAND_WIDTH  = 31;
   // Wide enough for a - (b +/- band) without overflow.
   localparam int CMP_WIDTH   = ((VALUE_WIDTH > BAND_WIDTH + 1) ? VALUE_WIDTH : BAND_WIDTH + 1)
                                + 2;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic [TIME_WIDTH-1:0]         time_type;
   typedef logic [SPAN_WIDTH-1:0]         span_type;
   typedef logic signed [CMP_WIDTH-1:0]   cmp_type;

   localparam value_type Q_ONE = value_type'(64'h10000);

   typedef enum logic [1:0] {
      REQ_SAMPLE = 2'd0,
      REQ_ACK    = 2'd1,
      REQ_CLEAR  = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      QUAL_VALID   = 2'd0,
      QUAL_UNAVAIL = 2'd1,
      QUAL_INVALID = 2'd2
   } quality_type;

   localparam logic [2:0] MODE_NONZERO = 3'd0;
   localparam logic [2:0] MODE_GT      = 3'd1;
   localparam logic [2:0] MODE_GE      = 3'd2;
   localparam logic [2:0] MODE_LT      = 3'd3;
   localparam logic [2:0] MODE_LE      = 3'd4;

   localparam logic [1:0] POL_UNAVAIL = 2'd0;
   localparam logic [1:0] POL_HOLD    = 2'd1;
   localparam logic [1:0] POL_WARN    = 2'd2;

   localparam logic [2:0] REG_COMPARE_MODE   = 3'd0;
   localparam logic [2:0] REG_BAND           = 3'd1;
   localparam logic [2:0] REG_DEBOUNCE_TICKS = 3'd2;
   localparam logic [2:0] REG_MISSING_POLICY = 3'd3;
   localparam logic [2:0] REG_MAX_HOLD_TICKS = 3'd4;

   typedef struct packed {
      logic [2:0]            compare_mode;
      logic [BAND_WIDTH-1:0] band;
      span_type              debounce_ticks;
      logic [1:0]            missing_policy;
      span_type              max_hold_ticks;
   } cfg_type;

   // One classified beat on its way from the front to the back.
   typedef struct packed {
      req_kind_type kind;
      logic         missing;
      logic         age_flag;
      logic         invalid;
      logic         desired_lo;   // decision when the last decision was off
      logic         desired_hi;   // decision when the last decision was on
      value_type    rule_value;
      time_type     now_ticks;
   } item_type;

   // True when now >= start + span; a time before start has not elapsed.
   function automatic logic elapsed(time_type now, time_type start, span_type span);
      time_type diff;
      diff = now - start;
      return (now >= start) && (diff >= TIME_WIDTH'(span));
   endfunction

endpackage

// ===== sv/alarm_hysteresis_debounce_latch_unit.sv =====
// Top level of the alarm qualifier: configuration registers, front end, queue, back end.
// Depends on ahdl_pkg, ahdl_front, ahdl_queue and ahdl_back.
//
//  channel   direction  handshake                         moves
//  req_      in         req_valid / req_ready             one sample, acknowledge or reset beat
//  rsp_      out        rsp_valid / rsp_ready             one result beat per request beat
//  p*        in/out     psel, penable, pwrite / pready    register write or read, 32-bit data
//
// A beat is taken every cycle in steady state while rsp_ready is high; a result passes
// through the queue and then through the back end's output register.
// The back end updates the alarm state as it pops each beat, which sets the rate at one beat
// per cycle. Reset is synchronous and returns every register but the output data and the
// queue slots to its reset value at once, with max_hold_ticks at one. When rsp_ready is low
// the output register holds and the two-entry queue absorbs what the front end has already
// taken; req_ready drops once it is full and returns in the cycle after the result is taken.
module alarm_hysteresis_debounce_latch_unit (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_type,
   input  logic                req_inputs_missing,
   input  logic                req_age_unknown_in,
   input  logic                req_value_invalid,
   input  ahdl_pkg::value_type req_rule_value,
   input  ahdl_pkg::value_type req_left_operand,
   input  ahdl_pkg::value_type req_right_operand,
   input  ahdl_pkg::time_type  req_now_ticks,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_quality,
   output logic                rsp_current_on,
   output logic                rsp_latched_on,
   output logic                rsp_age_unknown_out,
   output ahdl_pkg::value_type rsp_result_value,

   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [4:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   import ahdl_pkg::*;

   // The register file. Writes are only expected while the block is idle, so both ends
   // may read it directly without any shadowing.
   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       csr_write;
   logic [2:0] csr_index;

   item_type   front_item;
   item_type   head_item;
   logic       queue_not_full;
   logic       queue_not_empty;
   logic       queue_pop;
   logic       req_take;

   assign pready    = 1'b1;
   assign csr_index = paddr[4:2];
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_COMPARE_MODE:   cfg_in.compare_mode   = pwdata[2:0];
            REG_BAND:           cfg_in.band           = pwdata[BAND_WIDTH-1:0];
            REG_DEBOUNCE_TICKS: cfg_in.debounce_ticks = pwdata[SPAN_WIDTH-1:0];
            REG_MISSING_POLICY: cfg_in.missing_policy = pwdata[1:0];
            REG_MAX_HOLD_TICKS: cfg_in.max_hold_ticks = pwdata[SPAN_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_COMPARE_MODE:   prdata = 32'(cfg_ff.compare_mode);
         REG_BAND:           prdata = 32'(cfg_ff.band);
         REG_DEBOUNCE_TICKS: prdata = 32'(cfg_ff.debounce_ticks);
         REG_MISSING_POLICY: prdata = 32'(cfg_ff.missing_policy);
         REG_MAX_HOLD_TICKS: prdata = 32'(cfg_ff.max_hold_ticks);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.compare_mode   <= MODE_NONZERO;
         cfg_ff.band           <= '0;
         cfg_ff.debounce_ticks <= '0;
         cfg_ff.missing_policy <= POL_UNAVAIL;
         cfg_ff.max_hold_ticks <= span_type'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end only classifies; a request beat goes into the queue as it is taken.
   assign req_ready = queue_not_full;
   assign req_take  = req_valid && queue_not_full;

   ahdl_front u_front (
      .cfg                (cfg_ff),
      .req_type           (req_type),
      .req_inputs_missing (req_inputs_missing),
      .req_age_unknown_in (req_age_unknown_in),
      .req_value_invalid  (req_value_invalid),
      .req_rule_value     (req_rule_value),
      .req_left_operand   (req_left_operand),
      .req_right_operand  (req_right_operand),
      .req_now_ticks      (req_now_ticks),
      .item               (front_item)
   );

   ahdl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_take),
      .push_item (front_item),
      .not_full  (queue_not_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .head_item (head_item)
   );

   // The back end owns all alarm state and the output register.
   ahdl_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .item_valid          (queue_not_empty),
      .item                (head_item),
      .item_pop            (queue_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_quality         (rsp_quality),
      .rsp_current_on      (rsp_current_on),
      .rsp_latched_on      (rsp_latched_on),
      .rsp_age_unknown_out (rsp_age_unknown_out),
      .rsp_result_value    (rsp_result_value)
   );

endmodule

// ===== sv/ahdl_front.sv =====
// Front end: classifies a request beat and works out both hysteresis decisions.
// Depends on ahdl_pkg.
module ahdl_front (
   input  ahdl_pkg::cfg_type   cfg,
   input  logic [1:0]          req_type,
   input  logic                req_inputs_missing,
   input  logic                req_age_unknown_in,
   input  logic                req_value_invalid,
   input  ahdl_pkg::value_type req_rule_value,
   input  ahdl_pkg::value_type req_left_operand,
   input  ahdl_pkg::value_type req_right_operand,
   input  ahdl_pkg::time_type  req_now_ticks,
   output ahdl_pkg::item_type  item
);
   import ahdl_pkg::*;

   cmp_type left_x;
   cmp_type right_x;
   cmp_type band_x;
   cmp_type diff_base;
   cmp_type diff_up;     // a - (b + band)
   cmp_type diff_down;   // a - (b - band)
   logic    use_band;
   logic    greater;
   logic    nonzero;

   function automatic logic decide(logic [2:0] mode, cmp_type d);
      logic neg;
      logic zero;
      neg  = d[CMP_WIDTH-1];
      zero = (d == '0);
      unique case (mode)
         MODE_GT: return !neg && !zero;
         MODE_GE: return !neg;
         MODE_LT: return neg;
         default: return neg || zero;
      endcase
   endfunction

   always_comb begin
      left_x    = CMP_WIDTH'(req_left_operand);
      right_x   = CMP_WIDTH'(req_right_operand);
      band_x    = CMP_WIDTH'(cfg.band);
      diff_base = left_x - right_x;
      diff_up   = diff_base - band_x;
      diff_down = diff_base + band_x;
      nonzero   = (req_rule_value != '0);
      greater   = (cfg.compare_mode == MODE_GT) || (cfg.compare_mode == MODE_GE);
      use_band  = (cfg.band != '0) && (cfg.compare_mode >= MODE_GT)
                  && (cfg.compare_mode <= MODE_LE);

      item.kind        = req_kind_type'(req_type);
      item.missing     = req_inputs_missing;
      item.age_flag    = req_age_unknown_in;
      item.invalid     = req_value_invalid;
      item.rule_value  = req_rule_value;
      item.now_ticks   = req_now_ticks;
      if (use_band) begin
         // The band pushes the threshold away from the side last decided.
         item.desired_lo = decide(cfg.compare_mode, greater ? diff_up : diff_down);
         item.desired_hi = decide(cfg.compare_mode, greater ? diff_down : diff_up);
      end else begin
         item.desired_lo = nonzero;
         item.desired_hi = nonzero;
      end
   end

endmodule

// ===== sv/ahdl_queue.sv =====
// Two-entry queue of classified beats between the front and the back end.
// Depends on ahdl_pkg and assert_macros.svh.
module ahdl_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ahdl_pkg::item_type push_item,
   output logic               not_full,
   input  logic               pop,
   output logic               not_empty,
   output ahdl_pkg::item_type head_item
);
   import ahdl_pkg::*;
   `include "assert_macros.svh"

   item_type   slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   always_comb begin
      not_full  = (count_ff != 2'd2);
      not_empty = (count_ff != 2'd0);
      head_item = slot_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   `AHDL_ASSERT_NOW(a_no_pop_when_empty, clock, reset, pop, count_ff != 2'd0)
   `AHDL_ASSERT_NOW(a_no_push_when_full, clock, reset, push && !pop, count_ff != 2'd2)

endmodule

// ===== sv/ahdl_back.sv =====
// Back end: applies debounce, latch, hold and missing-input policy, registers the result.
// Depends on ahdl_pkg and assert_macros.svh.
module ahdl_back (
   input  logic                clock,
   input  logic                reset,
   input  ahdl_pkg::cfg_type   cfg,
   input  logic                item_valid,
   input  ahdl_pkg::item_type  item,
   output logic                item_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_quality,
   output logic                rsp_current_on,
   output logic                rsp_latched_on,
   output logic                rsp_age_unknown_out,
   output ahdl_pkg::value_type rsp_result_value
);
   import ahdl_pkg::*;
   `include "assert_macros.svh"

   logic        cur_on_ff,     cur_on_in;
   logic        latch_on_ff,   latch_on_in;
   quality_type quality_ff,    quality_in;
   logic        age_ff,        age_in;
   value_type   value_ff,      value_in;
   logic        hyst_side_ff,  hyst_side_in;
   logic        pend_active_ff, pend_active_in;
   logic        pend_target_ff, pend_target_in;
   time_type    pend_start_ff, pend_start_in;
   logic        hold_active_ff, hold_active_in;
   time_type    hold_start_ff, hold_start_in;

   logic        out_valid_ff,  out_valid_in;
   quality_type out_quality_ff, out_quality_in;
   logic        out_cur_ff,    out_cur_in;
   logic        out_latch_ff,  out_latch_in;
   logic        out_age_ff,    out_age_in;
   value_type   out_value_ff,  out_value_in;

   logic        advance;
   logic        desired;
   logic        new_pend;
   logic        hold_done;
   logic        pend_done;
   time_type    hold_ref;
   time_type    pend_ref;

   always_comb begin
      advance  = item_valid && (!out_valid_ff || rsp_ready);
      item_pop = advance;

      cur_on_in      = cur_on_ff;
      latch_on_in    = latch_on_ff;
      quality_in     = quality_ff;
      age_in         = age_ff;
      value_in       = value_ff;
      hyst_side_in   = hyst_side_ff;
      pend_active_in = pend_active_ff;
      pend_target_in = pend_target_ff;
      pend_start_in  = pend_start_ff;
      hold_active_in = hold_active_ff;
      hold_start_in  = hold_start_ff;

      desired   = hyst_side_ff ? item.desired_hi : item.desired_lo;
      new_pend  = !pend_active_ff || (pend_target_ff != desired);
      hold_ref  = hold_active_ff ? hold_start_ff : item.now_ticks;
      pend_ref  = new_pend ? item.now_ticks : pend_start_ff;
      hold_done = elapsed(item.now_ticks, hold_ref, cfg.max_hold_ticks);
      pend_done = elapsed(item.now_ticks, pend_ref, cfg.debounce_ticks);

      unique case (item.kind)
         REQ_SAMPLE: begin
            if (item.missing) begin
               pend_active_in = 1'b0;
               if (cfg.missing_policy == POL_HOLD && !hold_active_ff) begin
                  hold_active_in = 1'b1;
                  hold_start_in  = item.now_ticks;
               end
               // While a hold runs the stored result stands unchanged.
               if (cfg.missing_policy != POL_HOLD || hold_done) begin
                  age_in = item.age_flag;
                  if (cfg.missing_policy == POL_WARN) begin
                     quality_in  = QUAL_VALID;
                     cur_on_in   = 1'b1;
                     latch_on_in = 1'b1;
                     value_in    = Q_ONE;
                  end else begin
                     quality_in = QUAL_UNAVAIL;
                     value_in   = '0;
                     cur_on_in  = 1'b0;
                  end
               end
            end else begin
               hold_active_in = 1'b0;
               age_in         = item.age_flag;
               if (item.invalid) begin
                  quality_in     = QUAL_INVALID;
                  value_in       = '0;
                  cur_on_in      = 1'b0;
                  pend_active_in = 1'b0;
               end else begin
                  hyst_side_in = desired;
                  if (desired == cur_on_ff) begin
                     pend_active_in = 1'b0;
                  end else begin
                     if (new_pend) begin
                        pend_active_in = 1'b1;
                        pend_target_in = desired;
                        pend_start_in  = item.now_ticks;
                     end
                     if (pend_done) begin
                        cur_on_in      = desired;
                        pend_active_in = 1'b0;
                     end
                  end
                  quality_in  = QUAL_VALID;
                  value_in    = item.rule_value;
                  latch_on_in = latch_on_ff || cur_on_in;
               end
            end
         end
         REQ_ACK: begin
            latch_on_in = 1'b0;
         end
         REQ_CLEAR: begin
            cur_on_in      = 1'b0;
            latch_on_in    = 1'b0;
            quality_in     = QUAL_VALID;
            age_in         = 1'b0;
            value_in       = '0;
            hyst_side_in   = 1'b0;
            pend_active_in = 1'b0;
            pend_target_in = 1'b0;
            pend_start_in  = '0;
            hold_active_in = 1'b0;
            hold_start_in  = '0;
         end
         default: begin
         end
      endcase

      out_valid_in   = advance || (out_valid_ff && !rsp_ready);
      out_quality_in = quality_in;
      out_cur_in     = cur_on_in;
      out_latch_in   = latch_on_in;
      out_age_in     = age_in;
      out_value_in   = (quality_in == QUAL_VALID) ? value_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_on_ff      <= 1'b0;
         latch_on_ff    <= 1'b0;
         quality_ff     <= QUAL_VALID;
         age_ff         <= 1'b0;
         value_ff       <= '0;
         hyst_side_ff   <= 1'b0;
         pend_active_ff <= 1'b0;
         pend_target_ff <= 1'b0;
         pend_start_ff  <= '0;
         hold_active_ff <= 1'b0;
         hold_start_ff  <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            cur_on_ff      <= cur_on_in;
            latch_on_ff    <= latch_on_in;
            quality_ff     <= quality_in;
            age_ff         <= age_in;
            value_ff       <= value_in;
            hyst_side_ff   <= hyst_side_in;
            pend_active_ff <= pend_active_in;
            pend_target_ff <= pend_target_in;
            pend_start_ff  <= pend_start_in;
            hold_active_ff <= hold_active_in;
            hold_start_ff  <= hold_start_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_quality_ff <= out_quality_in;
         out_cur_ff     <= out_cur_in;
         out_latch_ff   <= out_latch_in;
         out_age_ff     <= out_age_in;
         out_value_ff   <= out_value_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_quality         = out_quality_ff;
   assign rsp_current_on      = out_cur_ff;
   assign rsp_latched_on      = out_latch_ff;
   assign rsp_age_unknown_out = out_age_ff;
   assign rsp_result_value    = out_value_ff;

   `AHDL_ASSERT_NOW(a_pend_differs, clock, reset, pend_active_ff, pend_target_ff != cur_on_ff)
   `AHDL_ASSERT_NOW(a_off_unless_valid, clock, reset, quality_ff != QUAL_VALID, !cur_on_ff)
   `AHDL_ASSERT_NEXT(a_state_frozen, clock, reset, !advance, $stable(cur_on_ff) && $stable(latch_on_ff))

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the alarm qualifier: directed beats, then random traffic.
// Depends on ahdl_pkg and alarm_hysteresis_debounce_latch_unit; predicts every result itself.
module testbench;
   import ahdl_pkg::*;

   // Codes that the package leaves unnamed; the block must treat them like the defaults.
   localparam logic [2:0] MODE_SPARE = 3'd7;
   localparam logic [1:0] POL_SPARE  = 2'd3;

   // One request beat as it stands on the input channel.
   typedef struct {
      req_kind_type kind;
      logic         missing;
      logic         age_flag;
      logic         invalid;
      value_type    rule_value;
      value_type    left_operand;
      value_type    right_operand;
      time_type     now_ticks;
   } alarm_beat_type;

   // One result beat as it should leave the output channel.
   typedef struct {
      quality_type quality;
      logic        current_on;
      logic        latched_on;
      logic        age_flag;
      value_type   result_value;
   } alarm_report_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;

   logic      req_valid = 1'b0;
   logic      req_ready;
   logic [1:0] req_type = REQ_SAMPLE;
   logic      req_inputs_missing = 1'b0;
   logic      req_age_unknown_in = 1'b0;
   logic      req_value_invalid = 1'b0;
   value_type req_rule_value = '0;
   value_type req_left_operand = '0;
   value_type req_right_operand = '0;
   time_type  req_now_ticks = '0;

   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   logic [1:0] rsp_quality;
   logic      rsp_current_on;
   logic      rsp_latched_on;
   logic      rsp_age_unknown_out;
   value_type rsp_result_value;

   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // Idling control: percentage of cycles in which the sender idles or the receiver stalls.
   int send_idle_pct  = 0;
   int sink_stall_pct = 0;
   int mismatch_count = 0;

   // Results predicted for accepted request beats, oldest first.
   alarm_report_type predicted_reports[$];

   // Time base of the random traffic; mostly creeps forwards, now and then jumps.
   time_type now_cursor = '0;

   // The testbench's own copy of the registers, at their reset values.
   logic [2:0]            cfg_mode     = MODE_NONZERO;
   logic [BAND_WIDTH-1:0] cfg_band     = '0;
   logic [31:0]           cfg_debounce = '0;
   logic [1:0]            cfg_policy   = POL_UNAVAIL;
   logic [31:0]           cfg_max_hold = 32'd1;

   // The testbench's own copy of the alarm state.
   logic        st_cur_on, st_latch_on, st_age_flag, st_hyst_side;
   logic        st_pend_active, st_pend_target, st_hold_active;
   quality_type st_quality;
   value_type   st_value;
   time_type    st_pend_start, st_hold_start;

   alarm_hysteresis_debounce_latch_unit DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_inputs_missing  (req_inputs_missing),
      .req_age_unknown_in  (req_age_unknown_in),
      .req_value_invalid   (req_value_invalid),
      .req_rule_value      (req_rule_value),
      .req_left_operand    (req_left_operand),
      .req_right_operand   (req_right_operand),
      .req_now_ticks       (req_now_ticks),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_quality         (rsp_quality),
      .rsp_current_on      (rsp_current_on),
      .rsp_latched_on      (rsp_latched_on),
      .rsp_age_unknown_out (rsp_age_unknown_out),
      .rsp_result_value    (rsp_result_value),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always #6 clock = ~clock;

   // The receiver stalls at random; with a zero percentage it is ready on every cycle.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
   end

   // ------------------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------------------

   function automatic void clear_alarm_state();
      st_cur_on      = 1'b0;
      st_latch_on    = 1'b0;
      st_age_flag    = 1'b0;
      st_hyst_side   = 1'b0;
      st_pend_active = 1'b0;
      st_pend_target = 1'b0;
      st_hold_active = 1'b0;
      st_quality     = QUAL_VALID;
      st_value       = '0;
      st_pend_start  = '0;
      st_hold_start  = '0;
   endfunction

   // True once now has reached start + span. A time before the start has not elapsed, so
   // a clock that steps backwards never wraps round into a huge difference.
   function automatic logic span_passed(time_type now, time_type start, logic [31:0] span);
      return (now >= start) && ((now - start) >= time_type'(span));
   endfunction

   // Applies one accepted beat to the state copy and returns the result it should produce.
   function automatic alarm_report_type qualify_beat(alarm_beat_type b);
      alarm_report_type r;
      logic          desired;
      logic          greater;
      longint        lhs, bound, shift;
      case (b.kind)
         REQ_SAMPLE: begin
            if (b.missing) begin
               st_pend_active = 1'b0;
               if (cfg_policy == POL_HOLD && !st_hold_active) begin
                  st_hold_active = 1'b1;
                  st_hold_start  = b.now_ticks;
               end
               // While a hold is still running the stored result stands untouched.
               if (cfg_policy != POL_HOLD ||
                   span_passed(b.now_ticks, st_hold_start, cfg_max_hold)) begin
                  st_age_flag = b.age_flag;
                  if (cfg_policy == POL_WARN) begin
                     st_quality  = QUAL_VALID;
                     st_cur_on   = 1'b1;
                     st_latch_on = 1'b1;
                     st_value    = Q_ONE;
                  end else begin
                     st_quality = QUAL_UNAVAIL;
                     st_value   = '0;
                     st_cur_on  = 1'b0;
                  end
               end
            end else begin
               st_hold_active = 1'b0;
               st_age_flag    = b.age_flag;
               if (b.invalid) begin
                  // Latch and hysteresis side survive an invalid value.
                  st_quality     = QUAL_INVALID;
                  st_value       = '0;
                  st_cur_on      = 1'b0;
                  st_pend_active = 1'b0;
               end else begin
                  desired = (b.rule_value != 0);
                  if (cfg_band != 0 && cfg_mode >= MODE_GT && cfg_mode <= MODE_LE) begin
                     // The threshold moves by the band, towards the side that makes a change
                     // of decision harder. 64-bit arithmetic keeps the bound exact.
                     greater = (cfg_mode <= MODE_GE);
                     lhs     = b.left_operand;
                     shift   = longint'(cfg_band);
                     if (greater == st_hyst_side)
                        shift = -shift;
                     bound = longint'(b.right_operand) + shift;
                     case (cfg_mode)
                        MODE_GT: desired = (lhs > bound);
                        MODE_GE: desired = (lhs >= bound);
                        MODE_LT: desired = (lhs < bound);
                        default: desired = (lhs <= bound);
                     endcase
                  end
                  st_hyst_side = desired;
                  if (desired == st_cur_on) begin
                     st_pend_active = 1'b0;
                  end else begin
                     if (!st_pend_active || st_pend_target != desired) begin
                        st_pend_active = 1'b1;
                        st_pend_target = desired;
                        st_pend_start  = b.now_ticks;
                     end
                     if (span_passed(b.now_ticks, st_pend_start, cfg_debounce)) begin
                        st_cur_on      = desired;
                        st_pend_active = 1'b0;
                     end
                  end
                  st_quality = QUAL_VALID;
                  st_value   = b.rule_value;
                  if (st_cur_on)
                     st_latch_on = 1'b1;
               end
            end
         end
         REQ_ACK:   st_latch_on = 1'b0;
         REQ_CLEAR: clear_alarm_state();
         default: ;
      endcase
      r.quality      = st_quality;
      r.current_on   = st_cur_on;
      r.latched_on   = st_latch_on;
      r.age_flag     = st_age_flag;
      r.result_value = (st_quality == QUAL_VALID) ? st_value : '0;
      return r;
   endfunction

   initial clear_alarm_state();

   // Every request beat accepted at this edge gets its prediction queued straight away.
   always @(posedge clock) begin : watch_requests
      alarm_beat_type seen;
      if (!reset && req_valid && req_ready) begin
         seen.kind          = req_kind_type'(req_type);
         seen.missing       = req_inputs_missing;
         seen.age_flag      = req_age_unknown_in;
         seen.invalid       = req_value_invalid;
         seen.rule_value    = req_rule_value;
         seen.left_operand  = req_left_operand;
         seen.right_operand = req_right_operand;
         seen.now_ticks     = req_now_ticks;
         predicted_reports.push_back(qualify_beat(seen));
      end
   end

   // ------------------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------------------

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Each result beat is matched against the oldest prediction, field by field.
   always @(posedge clock) begin : check_reports
      alarm_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_reports.size() == 0) begin
            $display("%0t: result beat with no request outstanding, expected none, got %0h",
                     $time, rsp_result_value);
            mismatch_count++;
         end else begin
            want = predicted_reports.pop_front();
            check_field("quality", want.quality, rsp_quality);
            check_field("current_on", want.current_on, rsp_current_on);
            check_field("latched_on", want.latched_on, rsp_latched_on);
            check_field("age_unknown_out", want.age_flag, rsp_age_unknown_out);
            check_field("result_value", want.result_value, rsp_result_value);
         end
      end
   end

   // ------------------------------------------------------------------------------------
   // Drivers. Every task starts and ends just after a rising edge.
   // ------------------------------------------------------------------------------------

   // Offers one request beat and returns at the edge that accepts it. Any idle cycles are
   // spent before valid rises, so valid never drops while a beat is on offer.
   task automatic send_beat(alarm_beat_type b);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid          <= 1'b1;
      req_type           <= b.kind;
      req_inputs_missing <= b.missing;
      req_age_unknown_in <= b.age_flag;
      req_value_invalid  <= b.invalid;
      req_rule_value     <= b.rule_value;
      req_left_operand   <= b.left_operand;
      req_right_operand  <= b.right_operand;
      req_now_ticks      <= b.now_ticks;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stops the sender and waits until every predicted result has been seen, then lets the
   // two-stage pipeline settle a little longer.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predicted_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] index, logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (index)
         REG_COMPARE_MODE:   cfg_mode     = data[2:0];
         REG_BAND:           cfg_band     = data[BAND_WIDTH-1:0];
         REG_DEBOUNCE_TICKS: cfg_debounce = data;
         REG_MISSING_POLICY: cfg_policy   = data[1:0];
         REG_MAX_HOLD_TICKS: cfg_max_hold = data;
         default: ;
      endcase
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Reads a register back and compares it with the copy held here.
   task automatic csr_read(logic [2:0] index);
      logic [31:0] want;
      case (index)
         REG_COMPARE_MODE:   want = 32'(cfg_mode);
         REG_BAND:           want = 32'(cfg_band);
         REG_DEBOUNCE_TICKS: want = cfg_debounce;
         REG_MISSING_POLICY: want = 32'(cfg_policy);
         default:            want = cfg_max_hold;
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {index, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      check_field($sformatf("register %0d", index), want, prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Registers are only touched once the block has gone quiet.
   task automatic set_config(logic [2:0] mode, logic [BAND_WIDTH-1:0] band,
                             logic [31:0] debounce, logic [1:0] policy, logic [31:0] hold);
      wait_drained();
      csr_write(REG_COMPARE_MODE, 32'(mode));
      csr_write(REG_BAND, 32'(band));
      csr_write(REG_DEBOUNCE_TICKS, debounce);
      csr_write(REG_MISSING_POLICY, 32'(policy));
      csr_write(REG_MAX_HOLD_TICKS, hold);
      csr_read(REG_COMPARE_MODE);
      csr_read(REG_BAND);
      csr_read(REG_DEBOUNCE_TICKS);
      csr_read(REG_MISSING_POLICY);
      csr_read(REG_MAX_HOLD_TICKS);
   endtask

   function automatic alarm_beat_type make_beat(req_kind_type kind, logic missing,
                                                logic unknown, logic invalid,
                                                value_type rule, value_type left,
                                                value_type right, time_type now);
      alarm_beat_type b;
      b.kind          = kind;
      b.missing       = missing;
      b.age_flag      = unknown;
      b.invalid       = invalid;
      b.rule_value    = rule;
      b.left_operand  = left;
      b.right_operand = right;
      b.now_ticks     = now;
      return b;
   endfunction

   function automatic value_type saturate_value(longint v);
      if (v > 64'sh7FFF_FFFF)
         return value_type'(32'h7FFF_FFFF);
      if (v < -64'sh8000_0000)
         return value_type'(32'h8000_0000);
      return value_type'(v);
   endfunction

   // Mostly well-formed samples with operands close to the threshold, so that the band and
   // the debounce are actually exercised; the rest is acknowledges, clears, unknown codes,
   // missing or invalid inputs and the odd jump in time.
   function automatic alarm_beat_type random_beat();
      alarm_beat_type b;
      int          pick;
      longint      spread;
      pick = $urandom_range(0, 99);
      if (pick < 88)      b.kind = REQ_SAMPLE;
      else if (pick < 94) b.kind = REQ_ACK;
      else if (pick < 97) b.kind = REQ_CLEAR;
      else                b.kind = REQ_NONE;
      b.missing  = ($urandom_range(0, 99) < 12);
      b.invalid  = ($urandom_range(0, 99) < 8);
      b.age_flag = 1'($urandom_range(0, 1));

      pick = $urandom_range(0, 99);
      if (pick < 30)      b.rule_value = '0;
      else if (pick < 34) b.rule_value = value_type'(32'h7FFF_FFFF);
      else if (pick < 38) b.rule_value = value_type'(32'h8000_0000);
      else if (pick < 45) b.rule_value = Q_ONE;
      else                b.rule_value = value_type'($urandom);

      pick = $urandom_range(0, 99);
      if (pick < 50)
         b.right_operand = value_type'(longint'($urandom_range(0, 32'h40000)) - 64'sh20000);
      else if (pick < 90)
         b.right_operand = value_type'($urandom);
      else if (pick < 95)
         b.right_operand = value_type'(32'h7FFF_FFFF);
      else
         b.right_operand = value_type'(32'h8000_0000);
      if ($urandom_range(0, 99) < 75) begin
         spread = 2 * longint'(cfg_band) + 4;
         b.left_operand = saturate_value(longint'(b.right_operand) +
                                         (longint'($urandom) % (2 * spread + 1)) - spread);
      end else begin
         b.left_operand = value_type'($urandom);
      end

      // Steps near the debounce and hold spans put edges right on their boundaries.
      pick = $urandom_range(0, 99);
      if (pick < 78)
         now_cursor = now_cursor + time_type'($urandom_range(0, 3));
      else if (pick < 86)
         now_cursor = now_cursor + time_type'(cfg_debounce)
                      + time_type'($urandom_range(0, 2)) - time_type'(1);
      else if (pick < 92)
         now_cursor = now_cursor + time_type'(cfg_max_hold)
                      + time_type'($urandom_range(0, 2)) - time_type'(1);
      else if (pick < 95)
         now_cursor = time_type'({$urandom, $urandom});
      else
         now_cursor = now_cursor - time_type'($urandom_range(1, 3));
      b.now_ticks = now_cursor;
      return b;
   endfunction

   // ------------------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------------------

   // Registers read back their reset values; then the plain nonzero decision with the
   // value extremes, acknowledge, an unknown request code, unavailable, invalid and clear.
   task automatic test_power_on_defaults();
      csr_read(REG_COMPARE_MODE);
      csr_read(REG_BAND);
      csr_read(REG_DEBOUNCE_TICKS);
      csr_read(REG_MISSING_POLICY);
      csr_read(REG_MAX_HOLD_TICKS);
      send_beat(make_beat(REQ_SAMPLE, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0));
      send_beat(make_beat(REQ_SAMPLE, 0, 1, 0, 32'h8000_0000, 32'h8000_0000, '1, 1));
      send_beat(make_beat(REQ_SAMPLE, 0, 0, 0, 0, '1, 32'h8000_0000, 2));
      send_beat(make_beat(REQ_ACK, 1, 1, 1, '1, '1, '1, '1));
      send_beat(make_beat(REQ_NONE, 1, 1, 1, 5, 5, 5, 3));
      send_beat(make_beat(REQ_SAMPLE, 1, 1, 0, 7, 0, 0, 4));
      send_beat(make_beat(REQ_SAMPLE, 0, 0, 1, 7, 0, 0, 5));
      send_beat(make_beat(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 6));
   endtask

   // With the widest band the moved threshold lies outside the value range and must be
   // compared exactly, not wrapped.
   task automatic test_band_limits();
      set_config(MODE_GT, 31'h7FFF_FFFF, 32'd0, POL_UNAVAIL, 32'd1);
      send_beat(make_beat(REQ_SAMPLE, 0, 0, 0, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 10));
      send_beat(make_beat(REQ_SAMPLE, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 11));
      send_beat(make_beat(REQ_SAMPLE, 0, 0, 0, 1, 32'h8000_0000, 32'h7FFF_FFFF, 12));
   endtask

   // A change must persist for the debounce span; time stepping backwards does not count.
   task automatic test_debounce_timing();
      set_config(MODE_NONZERO, '0, 32'd5, POL_UNAVAIL, 32'd1);
      send_beat(make_beat(REQ_SAMPLE, 0, 0, 0, 1, 0, 0, 100));
      send_beat(make_beat(REQ_SAMPLE, 0, 0, 0, 1, 0, 0, 97));
      send_beat(make_beat(REQ_SAMPLE, 0, 0, 0, 1, 0, 0, 105));
   endtask

   // Hold with a zero span expires at once; a running hold reports the stored result,
   // age flag included; then forced warning and the spare policy code.
   task automatic test_missing_policies();
      set_config(MODE_NONZERO, '0, 32'd0, POL_HOLD, 32'd0);
      send_beat(make_beat(REQ_SAMPLE, 1, 1, 0, 3, 0, 0, 200));
      set_config(MODE_NONZERO, '0, 32'd0, POL_HOLD, 32'd3);
      send_beat(make_beat(REQ_SAMPLE, 0, 0, 0, 5, 0, 0, 300));
      send_beat(make_beat(REQ_SAMPLE, 1, 1, 0, 9, 0, 0, 301));
      send_beat(make_beat(REQ_SAMPLE, 1, 1, 0, 9, 0, 0, 304));
      set_config(MODE_NONZERO, '0, 32'd0, POL_WARN, 32'hFFFF_FFFF);
      send_beat(make_beat(REQ_SAMPLE, 1, 0, 0, 0, 0, 0, 310));
      set_config(MODE_SPARE, 31'd1, 32'd0, POL_SPARE, 32'd1);
      send_beat(make_beat(REQ_SAMPLE, 1, 0, 0, 0, 0, 0, 320));
      send_beat(make_beat(REQ_SAMPLE, 0, 0, 0, 0, 32'h10, 0, 321));
   endtask

   // Sixteen phases of random traffic. Each phase has its own register setting, with the
   // extremes forced in some of them, and one of four idling patterns.
   task automatic test_random_traffic();
      logic [2:0]            mode;
      logic [BAND_WIDTH-1:0] band;
      logic [31:0]           debounce, hold;
      now_cursor = 48'd1000;
      for (int phase = 0; phase < 16; phase++) begin
         mode = (phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7));
         if (phase % 5 == 3)      band = '1;
         else if (phase % 5 == 0) band = '0;
         else                     band = BAND_WIDTH'($urandom_range(1, 32'h40000));
         if (phase == 6)          debounce = 32'hFFFF_FFFF;
         else if (phase % 3 == 0) debounce = '0;
         else                     debounce = $urandom_range(1, 8);
         if (phase == 9)          hold = 32'hFFFF_FFFF;
         else if (phase % 5 == 1) hold = '0;
         else                     hold = $urandom_range(1, 12);
         set_config(mode, band, debounce, 2'(phase % 4), hold);
         case (phase % 4)
            0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin send_idle_pct = 50; sink_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  sink_stall_pct = 50; end
            default: begin send_idle_pct = 35; sink_stall_pct = 35; end
         endcase
         for (int n = 0; n < 125; n++) begin
            send_beat(random_beat());
            // Once, the sender holds back in mid-phase until the queue is empty.
            if (phase == 2 && n == 60)
               wait_drained();
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_power_on_defaults();
      test_band_limits();
      test_debounce_timing();
      test_missing_policies();
      test_random_traffic();
      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Watchdog for a hung run; a correct run finishes long before it fires.
   initial begin
      #(12 * 500000);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
